>>> sv/set_assoc_writeback_cache_model_defines.svh
// assertion macros for the cache model
`ifndef SET_ASSOC_WRITEBACK_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_MODEL_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define SAC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cache model assertion failed");
// checked at every edge, reset included
`define SAC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cache model assertion failed");
`else
`define SAC_ASSERT(label, prop)
`define SAC_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> sv/sacache_pkg.sv
package sacache_pkg;

    localparam int ADDR_W    = 32;
    localparam int CMD_W     = 2;
    localparam int SETS      = 8;
    localparam int SET_W     = 3;
    localparam int SET_LSB   = 5;
    localparam int TAG_LSB   = 8;
    localparam int TAG_W     = 24;
    localparam int LAT_W     = 10;
    localparam int OLAT_W    = 12;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;
    localparam int OUT_W     = 176;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKUP_LAT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LAT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_LAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WCACHE_LAT  = 3'd4;

    // register reset values
    localparam logic [LAT_W-1:0] RST_LOOKUP_LAT = 10'd1;
    localparam logic [LAT_W-1:0] RST_READ_LAT   = 10'd100;
    localparam logic [LAT_W-1:0] RST_WRITE_LAT  = 10'd100;
    localparam logic [LAT_W-1:0] RST_WCACHE_LAT = 10'd1;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit_acc;
        logic drain_step;
        logic commit_drain;
    } sacache_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic drain_last;
    } sacache_sts_t;

endpackage

>>> sv/sacache_ctrl.sv
module sacache_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic [sacache_pkg::CMD_W-1:0]   in_cmd,
    output logic                            s_axis_tready,
    input  sacache_pkg::sacache_sts_t       sts,
    output sacache_pkg::sacache_cmd_t       ctl
);
    import sacache_pkg::*;

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_ACCESS    = 2'd1;
    localparam logic [1:0] ST_DRAIN     = 2'd2;
    localparam logic [1:0] ST_DRAIN_END = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        ctl.accept       = 1'b0;
        ctl.commit_acc   = 1'b0;
        ctl.drain_step   = 1'b0;
        ctl.commit_drain = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ctl.accept = 1'b1;
                    state_next = (in_cmd == CMD_DRAIN) ? ST_DRAIN : ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (sts.out_free)
                begin
                    ctl.commit_acc = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                ctl.drain_step = 1'b1;
                if (sts.drain_last)
                    state_next = ST_DRAIN_END;
            end
            ST_DRAIN_END:
            begin
                if (sts.out_free)
                begin
                    ctl.commit_drain = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/sacache_dp.sv
module sacache_dp #(
    parameter int NUM_WAYS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sacache_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacache_pkg::CFG_W-1:0]       cfg_data,
    input  logic [sacache_pkg::CMD_W-1:0]       in_cmd,
    input  logic [sacache_pkg::ADDR_W-1:0]      in_addr,
    input  sacache_pkg::sacache_cmd_t           ctl,
    output sacache_pkg::sacache_sts_t           sts,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sacache_pkg::OUT_W-1:0]       m_axis_tdata
);
    import sacache_pkg::*;

    localparam int PTR_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ROW_W  = NUM_WAYS * TAG_W;
    localparam int DCNT_W = $clog2(SETS * NUM_WAYS + 1);
    localparam int PCNT_W = $clog2(NUM_WAYS + 1);
    localparam int PAD_W  = OUT_W - (OLAT_W + 2 + 5 * CNT_W);

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // configuration
    logic             enable_reg;
    logic [LAT_W-1:0] lookup_lat_reg;
    logic [LAT_W-1:0] read_lat_reg;
    logic [LAT_W-1:0] write_lat_reg;
    logic [LAT_W-1:0] wcache_lat_reg;

    // captured item
    logic [CMD_W-1:0] cmd_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SET_W-1:0] set_reg;

    // tag memory, one row per set
    logic [ROW_W-1:0] tag_mem [SETS];
    logic [ROW_W-1:0] tag_row_reg;
    logic             row_rd_valid_reg;
    logic [SETS-1:0]  row_valid_reg;

    logic [NUM_WAYS-1:0] dirty_reg [SETS];
    logic [PTR_W-1:0]    ptr_reg   [SETS];

    logic [SET_W-1:0]  drain_row_reg;
    logic [DCNT_W-1:0] drain_sum_reg;

    logic [CNT_W-1:0] loads_reg;
    logic [CNT_W-1:0] stores_reg;
    logic [CNT_W-1:0] load_miss_reg;
    logic [CNT_W-1:0] store_miss_reg;
    logic [CNT_W-1:0] wb_cnt_reg;

    logic              out_valid_reg;
    logic [OLAT_W-1:0] out_lat_reg;
    logic              out_hit_reg;
    logic              out_wb_reg;

    logic [ROW_W-1:0]    eff_row;
    logic [ROW_W-1:0]    new_row;
    logic [NUM_WAYS-1:0] match;
    logic                found;
    logic [PTR_W-1:0]    hit_way;
    logic [PTR_W-1:0]    victim;
    logic [PTR_W-1:0]    victim_next;
    logic [NUM_WAYS-1:0] dirty_row;
    logic [NUM_WAYS-1:0] dirty_row_next;
    logic [SET_W-1:0]    rd_set;
    logic [PCNT_W-1:0]   pcnt;
    logic                is_load;
    logic                is_store;
    logic                do_cache;
    logic                was_dirty;
    logic                miss;
    logic [OLAT_W-1:0]   lat_calc;
    logic                out_free;

    assign out_free       = !out_valid_reg || m_axis_tready;
    assign sts.out_free   = out_free;
    assign sts.drain_last = (drain_row_reg == SET_W'(SETS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            lookup_lat_reg <= RST_LOOKUP_LAT;
            read_lat_reg   <= RST_READ_LAT;
            write_lat_reg  <= RST_WRITE_LAT;
            wcache_lat_reg <= RST_WCACHE_LAT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:     enable_reg     <= cfg_data[0];
                REG_LOOKUP_LAT: lookup_lat_reg <= cfg_data;
                REG_READ_LAT:   read_lat_reg   <= cfg_data;
                REG_WRITE_LAT:  write_lat_reg  <= cfg_data;
                REG_WCACHE_LAT: wcache_lat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= in_cmd;
            tag_reg <= in_addr[TAG_LSB +: TAG_W];
            set_reg <= in_addr[SET_LSB +: SET_W];
        end
    end

    // registered read at accept, row write at commit of a miss
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            tag_row_reg      <= tag_mem[in_addr[SET_LSB +: SET_W]];
            row_rd_valid_reg <= row_valid_reg[in_addr[SET_LSB +: SET_W]];
        end
        if (ctl.commit_acc && do_cache && miss)
            tag_mem[set_reg] <= new_row;
    end

    assign eff_row  = row_rd_valid_reg ? tag_row_reg : '0;
    assign is_load  = (cmd_reg == CMD_LOAD);
    assign is_store = (cmd_reg == CMD_STORE);
    assign do_cache = (is_load || is_store) && enable_reg;

    always_comb
    begin
        hit_way = '0;
        for (int w = 0; w < NUM_WAYS; w++)
            match[w] = (eff_row[w*TAG_W +: TAG_W] == tag_reg);
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (match[w])
                hit_way = PTR_W'(w);
    end

    assign found     = |match;
    assign miss      = !found;
    assign rd_set    = (cmd_reg == CMD_DRAIN) ? drain_row_reg : set_reg;
    assign dirty_row = dirty_reg[rd_set];
    assign victim    = ptr_reg[set_reg];
    assign was_dirty = dirty_row[victim];
    assign victim_next = (victim == PTR_W'(NUM_WAYS - 1)) ? '0 : victim + 1'b1;

    always_comb
    begin
        new_row = eff_row;
        new_row[victim*TAG_W +: TAG_W] = tag_reg;
    end

    always_comb
    begin
        dirty_row_next = dirty_row;
        if (found)
        begin
            if (is_store)
                dirty_row_next[hit_way] = 1'b1;
        end
        else
            dirty_row_next[victim] = is_store;
    end

    always_comb
    begin
        pcnt = '0;
        for (int w = 0; w < NUM_WAYS; w++)
            pcnt = pcnt + PCNT_W'(dirty_row[w]);
    end

    always_comb
    begin
        lat_calc = '0;
        if (is_load || is_store)
        begin
            if (!enable_reg)
                lat_calc = OLAT_W'(is_load ? read_lat_reg : write_lat_reg);
            else if (found)
                lat_calc = OLAT_W'(is_load ? lookup_lat_reg : wcache_lat_reg);
            else
                lat_calc = OLAT_W'(read_lat_reg)
                         + (was_dirty ? OLAT_W'(write_lat_reg) : '0)
                         + (is_store ? OLAT_W'(wcache_lat_reg) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            loads_reg      <= '0;
            stores_reg     <= '0;
            load_miss_reg  <= '0;
            store_miss_reg <= '0;
            wb_cnt_reg     <= '0;
            drain_row_reg  <= '0;
            drain_sum_reg  <= '0;
            for (int s = 0; s < SETS; s++)
            begin
                dirty_reg[s] <= '0;
                ptr_reg[s]   <= '0;
            end
        end
        else
        begin
            if (ctl.accept)
            begin
                drain_row_reg <= '0;
                drain_sum_reg <= '0;
            end
            if (ctl.drain_step)
            begin
                drain_row_reg <= drain_row_reg + 1'b1;
                drain_sum_reg <= drain_sum_reg + DCNT_W'(pcnt);
            end
            if (ctl.commit_drain)
                wb_cnt_reg <= sat_add(wb_cnt_reg, CNT_W'(drain_sum_reg));
            if (ctl.commit_acc && do_cache)
            begin
                dirty_reg[set_reg] <= dirty_row_next;
                if (is_load)
                    loads_reg <= sat_add(loads_reg, CNT_W'(1));
                else
                    stores_reg <= sat_add(stores_reg, CNT_W'(1));
                if (miss)
                begin
                    ptr_reg[set_reg]       <= victim_next;
                    row_valid_reg[set_reg] <= 1'b1;
                    if (is_load)
                        load_miss_reg <= sat_add(load_miss_reg, CNT_W'(1));
                    else
                        store_miss_reg <= sat_add(store_miss_reg, CNT_W'(1));
                    if (was_dirty)
                        wb_cnt_reg <= sat_add(wb_cnt_reg, CNT_W'(1));
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.commit_acc || ctl.commit_drain)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit_acc)
        begin
            out_lat_reg <= lat_calc;
            out_hit_reg <= do_cache && found;
            out_wb_reg  <= do_cache && miss && was_dirty;
        end
        else if (ctl.commit_drain)
        begin
            out_lat_reg <= '0;
            out_hit_reg <= 1'b0;
            out_wb_reg  <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, wb_cnt_reg, store_miss_reg, load_miss_reg,
                            stores_reg, loads_reg, out_wb_reg, out_hit_reg, out_lat_reg};

endmodule

>>> sv/set_assoc_writeback_cache_model.sv
// a load or store commits from the access state once the result register has room
// one access in flight: ready stays low from acceptance until the commit
// a drain walks the dirty bits one set per cycle, 8 sets, then commits
// reset (async, active low) clears dirty bits, victim pointers, counters and row valids
// tags read as zero until their set is first written, no clearing pass
`include "set_assoc_writeback_cache_model_defines.svh"

module set_assoc_writeback_cache_model #(
    parameter int NUM_WAYS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [sacache_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sacache_pkg::CFG_W-1:0]       cfg_data,
    // input item stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,   // address[31:0]
    input  logic [1:0]                          s_axis_tuser,   // cmd[1:0]
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // latency[11:0], hit[12], wrote_back[13], load_count[45:14],
    // store_count[77:46], load_miss_count[109:78], store_miss_count[141:110],
    // writeback_count[173:142], zero pad[175:174]
    output logic [sacache_pkg::OUT_W-1:0]       m_axis_tdata
);
    import sacache_pkg::*;

    // command and status between the state machine and the datapath
    sacache_cmd_t ctl;
    sacache_sts_t sts;

    // sequencer: idle, access commit, drain walk, drain commit
    sacache_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .in_cmd        (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .ctl           (ctl)
    );

    // tag memory, dirty and pointer flops, counters and result register
    sacache_dp #(
        .NUM_WAYS (NUM_WAYS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_cmd        (s_axis_tuser),
        .in_addr       (s_axis_tdata),
        .ctl           (ctl),
        .sts           (sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // a commit only happens when the result register can take it
    `SAC_ASSERT(a_commit_needs_room, (ctl.commit_acc || ctl.commit_drain) |-> sts.out_free)
    // ready is low in the cycle after an accepted transaction
    `SAC_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    // a result shows up only right after a commit
    `SAC_ASSERT(a_result_from_commit,
        $rose(m_axis_tvalid) |-> $past(ctl.commit_acc || ctl.commit_drain))
    // nothing is presented while reset is held
    `SAC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_axis_tvalid)

endmodule
